>>> hdl/tsp_pkg.sv
package tsp_pkg;

  // Register indexes of the configuration port
  localparam logic [3:0] REG_ANGLE_START = 4'd0;
  localparam logic [3:0] REG_ANGLE_STEP  = 4'd1;
  localparam logic [3:0] REG_ANGLE_END   = 4'd2;
  localparam logic [3:0] REG_RANGE_LOW   = 4'd3;
  localparam logic [3:0] REG_RANGE_HIGH  = 4'd4;
  localparam logic [3:0] REG_TILT_START  = 4'd5;
  localparam logic [3:0] REG_TILT_STEP   = 4'd6;
  localparam logic [3:0] REG_TILT_STOP   = 4'd7;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 18;

  // Angle landmarks, 65536 units per turn
  localparam logic [15:0]        QUARTER       = 16'd16384;
  localparam logic signed [17:0] QUARTER_S     = 18'sd16384;
  localparam logic signed [17:0] THREE_QUARTER = 18'sd49152;
  localparam logic signed [18:0] BEAM_MAX      = 19'sd131071;

  // Odd sine polynomial coefficients, Q30
  localparam logic signed [31:0] POLY_A = 32'sd1686629713;
  localparam logic signed [31:0] POLY_B = 32'sd693598669;
  localparam logic signed [31:0] POLY_C = 32'sd85569305;
  localparam logic signed [31:0] POLY_D = 32'sd5026998;

  localparam logic signed [31:0] SIN_MAX = 32'sd32767;

  // Post-operations of the shared multiplier
  typedef enum logic [2:0] {
    ALU_PASS,
    ALU_SQ4,
    ALU_SUBC30,
    ALU_SHR14,
    ALU_RND15,
    ALU_RND30
  } alu_op_t;

  // Work handed to the sequencer
  typedef struct packed {
    logic [15:0] beam_ph;
    logic [15:0] tilt;
    logic [15:0] range_mm;
  } job_t;

  // Finished point coordinates
  typedef struct packed {
    logic signed [16:0] z;
    logic signed [16:0] y;
    logic signed [16:0] x;
  } point_t;

endpackage

>>> hdl/tsp_alu.sv
module tsp_alu (
  input  tsp_pkg::alu_op_t   op,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  input  logic signed [31:0] op_c,
  output logic signed [31:0] res
);

  logic signed [63:0] prod;
  logic signed [63:0] sh;

  assign prod = $signed({{32{op_a[31]}}, op_a}) * $signed({{32{op_b[31]}}, op_b});

  // Scale, round or subtract the product
  always_comb begin
    sh  = '0;
    res = '0;
    case (op)
      tsp_pkg::ALU_PASS: begin
        res = prod[31:0];
      end
      tsp_pkg::ALU_SQ4: begin
        res = {prod[29:0], 2'b00};
      end
      tsp_pkg::ALU_SUBC30: begin
        sh  = prod >>> 30;
        res = op_c - sh[31:0];
      end
      tsp_pkg::ALU_SHR14: begin
        sh  = prod >>> 14;
        res = sh[31:0];
      end
      tsp_pkg::ALU_RND15: begin
        sh  = (prod + 64'sd16384) >>> 15;
        res = sh[31:0];
      end
      tsp_pkg::ALU_RND30: begin
        sh  = (prod + 64'sd536870912) >>> 30;
        res = sh[31:0];
      end
      default: begin
        res = '0;
      end
    endcase
  end

endmodule

>>> hdl/tsp_seq.sv
module tsp_seq #(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  tsp_pkg::job_t   job,
  input  logic            take,
  output logic            idle,
  output logic            res_valid,
  output tsp_pkg::point_t point
);

  localparam logic [15:0] QMASK = 16'hFFFF << (16 - TRIG_TABLE_BITS);

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_H1, S_H2, S_H3, S_FIN, S_RND,
    S_X, S_Y1, S_Y2, S_Z1, S_Z2, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [1:0]         k_r, k_nxt;
  tsp_pkg::job_t      job_r, job_nxt;
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [31:0] u2_r, u2_nxt;
  logic signed [15:0] trig_r [4];
  logic signed [15:0] trig_nxt [4];
  tsp_pkg::point_t    point_r, point_nxt;

  logic [15:0]        ang;
  logic [15:0]        ph;
  logic [1:0]         quad;
  logic [14:0]        f;
  logic signed [31:0] f_s;
  logic signed [31:0] range_s;
  logic signed [31:0] sb_neg;
  logic signed [31:0] cb_s;
  logic signed [31:0] st_s;
  logic signed [31:0] ct_s;
  logic signed [15:0] s_clamp;

  tsp_pkg::alu_op_t   alu_op;
  logic signed [31:0] alu_a;
  logic signed [31:0] alu_b;
  logic signed [31:0] alu_c;
  logic signed [31:0] alu_res;

  // Pick the angle of this pass: sin(b), cos(b), sin(t), cos(t)
  always_comb begin
    case (k_r)
      2'd0:    ang = job_r.beam_ph;
      2'd1:    ang = job_r.beam_ph + tsp_pkg::QUARTER;
      2'd2:    ang = job_r.tilt;
      2'd3:    ang = job_r.tilt + tsp_pkg::QUARTER;
      default: ang = job_r.beam_ph;
    endcase
  end

  // Quantize and fold into the first quarter wave
  assign ph   = ang & QMASK;
  assign quad = ph[15:14];
  assign f    = quad[0] ? (15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
  assign f_s  = {17'd0, f};

  assign range_s = {16'd0, job_r.range_mm};
  assign sb_neg  = -{{16{trig_r[0][15]}}, trig_r[0]};
  assign cb_s    = {{16{trig_r[1][15]}}, trig_r[1]};
  assign st_s    = {{16{trig_r[2][15]}}, trig_r[2]};
  assign ct_s    = {{16{trig_r[3][15]}}, trig_r[3]};

  // Operand selection for the shared multiplier
  always_comb begin
    alu_op = tsp_pkg::ALU_PASS;
    alu_a  = '0;
    alu_b  = '0;
    alu_c  = '0;
    case (state_r)
      S_SQ: begin
        alu_op = tsp_pkg::ALU_SQ4;
        alu_a  = f_s;
        alu_b  = f_s;
      end
      S_H1: begin
        alu_op = tsp_pkg::ALU_SUBC30;
        alu_a  = tsp_pkg::POLY_D;
        alu_b  = u2_r;
        alu_c  = tsp_pkg::POLY_C;
      end
      S_H2: begin
        alu_op = tsp_pkg::ALU_SUBC30;
        alu_a  = acc_r;
        alu_b  = u2_r;
        alu_c  = tsp_pkg::POLY_B;
      end
      S_H3: begin
        alu_op = tsp_pkg::ALU_SUBC30;
        alu_a  = acc_r;
        alu_b  = u2_r;
        alu_c  = tsp_pkg::POLY_A;
      end
      S_FIN: begin
        alu_op = tsp_pkg::ALU_SHR14;
        alu_a  = acc_r;
        alu_b  = f_s;
      end
      S_RND: begin
        alu_op = tsp_pkg::ALU_RND15;
        alu_a  = acc_r;
        alu_b  = 32'sd1;
      end
      S_X: begin
        alu_op = tsp_pkg::ALU_RND15;
        alu_a  = sb_neg;
        alu_b  = range_s;
      end
      S_Y1: begin
        alu_op = tsp_pkg::ALU_PASS;
        alu_a  = cb_s;
        alu_b  = st_s;
      end
      S_Z1: begin
        alu_op = tsp_pkg::ALU_PASS;
        alu_a  = ct_s;
        alu_b  = cb_s;
      end
      S_Y2, S_Z2: begin
        alu_op = tsp_pkg::ALU_RND30;
        alu_a  = acc_r;
        alu_b  = range_s;
      end
      default: begin
        alu_op = tsp_pkg::ALU_PASS;
      end
    endcase
  end

  tsp_alu u_alu (
    .op   (alu_op),
    .op_a (alu_a),
    .op_b (alu_b),
    .op_c (alu_c),
    .res  (alu_res)
  );

  // Clamp the rounded sine to full scale
  assign s_clamp = (alu_res > tsp_pkg::SIN_MAX) ? 16'sd32767 : alu_res[15:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    job_nxt   = job_r;
    acc_nxt   = acc_r;
    u2_nxt    = u2_r;
    trig_nxt  = trig_r;
    point_nxt = point_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          job_nxt   = job;
          k_nxt     = 2'd0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        u2_nxt    = alu_res;
        state_nxt = S_H1;
      end
      S_H1: begin
        acc_nxt   = alu_res;
        state_nxt = S_H2;
      end
      S_H2: begin
        acc_nxt   = alu_res;
        state_nxt = S_H3;
      end
      S_H3: begin
        acc_nxt   = alu_res;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        acc_nxt   = alu_res;
        state_nxt = S_RND;
      end
      S_RND: begin
        trig_nxt[k_r] = quad[1] ? -s_clamp : s_clamp;
        if (k_r == 2'd3) begin
          state_nxt = S_X;
        end else begin
          k_nxt     = k_r + 2'd1;
          state_nxt = S_SQ;
        end
      end
      S_X: begin
        point_nxt.x = alu_res[16:0];
        state_nxt   = S_Y1;
      end
      S_Y1: begin
        acc_nxt   = alu_res;
        state_nxt = S_Y2;
      end
      S_Y2: begin
        point_nxt.y = alu_res[16:0];
        state_nxt   = S_Z1;
      end
      S_Z1: begin
        acc_nxt   = alu_res;
        state_nxt = S_Z2;
      end
      S_Z2: begin
        point_nxt.z = alu_res[16:0];
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    k_r     <= k_nxt;
    job_r   <= job_nxt;
    acc_r   <= acc_nxt;
    u2_r    <= u2_nxt;
    trig_r  <= trig_nxt;
    point_r <= point_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign point     = point_r;

endmodule

>>> hdl/tilted_scan_to_point.sv
// Each kept sample runs through the single shared 32x32 multiplier: six passes
// for each of four sines, then five for the coordinates. A kept sample holds
// the input off until its point moves into the output register; a dropped
// sample leaves the input ready.
// Reset: synchronous, active low; registers return to their defaults, beam and
// tilt to the default start angles, and the output empties.
module tilted_scan_to_point #(
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: range_mm [15:0], intensity [31:16]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tlast,
  // out_tdata: point_x [16:0], point_y [33:17], point_z [50:34],
  //            point_intensity [66:51], zero [71:67]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [tsp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tsp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic signed [17:0] angle_start_r;
  logic [15:0]        angle_step_r;
  logic signed [17:0] angle_end_r;
  logic [15:0]        range_low_r;
  logic [15:0]        range_high_r;
  logic [15:0]        tilt_start_r;
  logic [15:0]        tilt_step_r;
  logic [15:0]        tilt_stop_r;

  logic signed [17:0] beam_r, beam_nxt;
  logic [15:0]        tilt_r, tilt_nxt;

  logic [15:0]        intensity_r;
  logic               out_valid_r;
  tsp_pkg::point_t    out_point_r;
  logic [15:0]        out_inten_r;

  logic [15:0]        range_mm;
  logic               in_acc;
  logic               keep;
  logic signed [18:0] beam_sum;
  logic signed [16:0] tilt_diff;

  tsp_pkg::job_t      job;
  tsp_pkg::point_t    seq_point;
  logic               seq_idle;
  logic               seq_valid;
  logic               take;

  assign range_mm  = in_tdata[15:0];
  assign in_tready = seq_idle;
  assign in_acc    = in_tvalid && in_tready;

  // Keep the sample only inside the beam window and the range limits
  assign keep = (beam_r < angle_end_r) &&
                ((beam_r < tsp_pkg::QUARTER_S) || (beam_r > tsp_pkg::THREE_QUARTER)) &&
                (range_mm > range_low_r) && (range_mm < range_high_r);

  assign job.beam_ph  = beam_r[15:0];
  assign job.tilt     = tilt_r;
  assign job.range_mm = range_mm;

  // Advance the beam, or restart it and step the tilt at scan end
  assign beam_sum  = {beam_r[17], beam_r} + {3'd0, angle_step_r};
  assign tilt_diff = {1'b0, tilt_r} - {1'b0, tilt_step_r};

  always_comb begin
    beam_nxt = beam_r;
    tilt_nxt = tilt_r;
    if (in_acc) begin
      if (in_tlast) begin
        beam_nxt = angle_start_r;
        if (tilt_diff < $signed({1'b0, tilt_stop_r})) begin
          tilt_nxt = tilt_start_r;
        end else begin
          tilt_nxt = tilt_diff[15:0];
        end
      end else if (beam_sum > tsp_pkg::BEAM_MAX) begin
        beam_nxt = tsp_pkg::BEAM_MAX[17:0];
      end else begin
        beam_nxt = beam_sum[17:0];
      end
    end
  end

  // Configuration registers and scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r <= -18'sd32768;
      angle_step_r  <= 16'd182;
      angle_end_r   <= 18'sd32768;
      range_low_r   <= 16'd5;
      range_high_r  <= 16'd3000;
      tilt_start_r  <= 16'd32768;
      tilt_step_r   <= 16'd182;
      tilt_stop_r   <= 16'd8192;
      beam_r        <= -18'sd32768;
      tilt_r        <= 16'd32768;
    end else begin
      beam_r <= beam_nxt;
      tilt_r <= tilt_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          tsp_pkg::REG_ANGLE_START: angle_start_r <= cfg_wdata;
          tsp_pkg::REG_ANGLE_STEP:  angle_step_r  <= cfg_wdata[15:0];
          tsp_pkg::REG_ANGLE_END:   angle_end_r   <= cfg_wdata;
          tsp_pkg::REG_RANGE_LOW:   range_low_r   <= cfg_wdata[15:0];
          tsp_pkg::REG_RANGE_HIGH:  range_high_r  <= cfg_wdata[15:0];
          tsp_pkg::REG_TILT_START:  tilt_start_r  <= cfg_wdata[15:0];
          tsp_pkg::REG_TILT_STEP:   tilt_step_r   <= cfg_wdata[15:0];
          tsp_pkg::REG_TILT_STOP:   tilt_stop_r   <= cfg_wdata[15:0];
          default: ;
        endcase
      end
    end
  end

  tsp_seq #(
    .TRIG_TABLE_BITS (TRIG_TABLE_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_acc && keep),
    .job       (job),
    .take      (take),
    .idle      (seq_idle),
    .res_valid (seq_valid),
    .point     (seq_point)
  );

  // Hold the intensity of the item in work
  always_ff @(posedge clk) begin
    if (in_acc && keep) begin
      intensity_r <= in_tdata[31:16];
    end
  end

  // Output register: load a finished point when the slot is free
  assign take = seq_valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (take) begin
      out_point_r <= seq_point;
      out_inten_r <= intensity_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_inten_r, out_point_r.z, out_point_r.y, out_point_r.x};

endmodule

>>> hdl/tsp_checker.sv
module tsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [31:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A new result appears only while the block was busy with an item
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without an item in work");

  // A zero range is always dropped and leaves the block ready
  a_zero_drop: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[15:0] == 16'd0) |=> in_tready)
    else $error("dropped item kept the block busy");

  // Reset empties the output and readies the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("bad state after reset");

endmodule

bind tilted_scan_to_point tsp_checker u_tsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/tilted_scan_to_point_tb.sv
`timescale 1ns / 1ps

module tilted_scan_to_point_tb;

  localparam int TRIG_BITS    = 10;
  localparam int TRIG_SHIFT   = 16 - TRIG_BITS;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int TOTAL_ITEMS  = 1450;
  localparam int PHASE_ITEMS  = 100;
  localparam int MAX_PHASES   = 40;
  localparam int MAX_PRINTS   = 50;
  localparam int REG_INDEX_TOP = 15;
  localparam int REG_INDEX_W  = tsp_pkg::CFG_ADDR_W;

  // Angle landmarks, 65536 units per turn
  localparam int QUARTER_TURN       = 16384;
  localparam int THREE_QUARTER_TURN = 49152;
  localparam int BEAM_TOP           = 131071;
  localparam logic [15:0] QUARTER_UNITS = 16'd16384;
  localparam logic [17:0] LOWEST_ANGLE  = 18'h20000;
  localparam logic [17:0] HIGHEST_ANGLE = 18'h1FFFF;

  // Quarter-wave sine polynomial, Q30
  localparam longint SIN_K1 = 1686629713;
  localparam longint SIN_K3 = 693598669;
  localparam longint SIN_K5 = 85569305;
  localparam longint SIN_K7 = 5026998;

  typedef struct packed {
    logic [16:0] x;
    logic [16:0] y;
    logic [16:0] z;
    logic [15:0] inten;
  } point_exp_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // in_tdata: range_mm [15:0], intensity [31:16]
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  // out_tdata: point_x [16:0], point_y [33:17], point_z [50:34],
  //            point_intensity [66:51], zero [71:67]
  logic [71:0] out_tdata;
  logic        cfg_wr_en;
  logic [tsp_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [tsp_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Predicted register file and scan state
  logic signed [17:0] beam_first, beam_limit, beam_pos;
  logic [15:0] beam_incr, min_range, max_range;
  logic [15:0] tilt_first, tilt_decr, tilt_floor, tilt_pos;

  point_exp_t expected_points[$];
  int  err_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  steady_flow = 1'b0;

  tilted_scan_to_point #(.TRIG_TABLE_BITS(TRIG_BITS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [16:0] got,
                                 input logic [16:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("[%0t] %s: got 0x%05h expected 0x%05h", $time, what, got, want);
  endtask

  // Q1.15 sine of a 16-bit angle, quantized to the trig table resolution
  function automatic longint sine_q15(input logic [15:0] ang);
    logic [15:0] ph;
    longint f, u, u2, t, s;
    ph = (ang >> TRIG_SHIFT) << TRIG_SHIFT;
    f = longint'(ph[13:0]);
    if (ph[14]) f = QUARTER_TURN - f;
    u = f <<< 16;
    u2 = (u * u) >>> 30;
    t = SIN_K7;
    t = SIN_K5 - ((t * u2) >>> 30);
    t = SIN_K3 - ((t * u2) >>> 30);
    t = SIN_K1 - ((t * u2) >>> 30);
    s = (t * u) >>> 30;
    s = (s + 16384) >>> 15;
    if (s > 32767) s = 32767;
    if (ph[15]) s = -s;
    return s;
  endfunction

  // Work out the point of one accepted sample and advance the scan state
  task automatic predict_sample(input logic [15:0] rng, input logic [15:0] lum,
                                input bit last);
    longint sb, cb, st, ct, r, x, y, z;
    int nb, nt;
    point_exp_t p;
    r = longint'(rng);
    if (beam_pos < beam_limit &&
        (int'(beam_pos) < QUARTER_TURN || int'(beam_pos) > THREE_QUARTER_TURN) &&
        rng > min_range && rng < max_range) begin
      sb = sine_q15(beam_pos[15:0]);
      cb = sine_q15(16'(beam_pos[15:0] + QUARTER_UNITS));
      st = sine_q15(tilt_pos);
      ct = sine_q15(16'(tilt_pos + QUARTER_UNITS));
      x = (-(sb * r) + (longint'(1) <<< 14)) >>> 15;
      y = (cb * st * r + (longint'(1) <<< 29)) >>> 30;
      z = (ct * cb * r + (longint'(1) <<< 29)) >>> 30;
      p.x = x[16:0];
      p.y = y[16:0];
      p.z = z[16:0];
      p.inten = lum;
      expected_points = {expected_points, p};
    end
    if (last) begin
      nt = int'(tilt_pos) - int'(tilt_decr);
      beam_pos = beam_first;
      if (nt < int'(tilt_floor)) tilt_pos = tilt_first;
      else tilt_pos = nt[15:0];
    end else begin
      nb = int'(beam_pos) + int'(beam_incr);
      if (nb > BEAM_TOP) nb = BEAM_TOP;
      beam_pos = nb[17:0];
    end
  endtask

  // Write one register and mirror it in the predictor; block must be idle
  task automatic write_reg(input logic [tsp_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [17:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      tsp_pkg::REG_ANGLE_START: beam_first = val;
      tsp_pkg::REG_ANGLE_STEP:  beam_incr  = val[15:0];
      tsp_pkg::REG_ANGLE_END:   beam_limit = val;
      tsp_pkg::REG_RANGE_LOW:   min_range  = val[15:0];
      tsp_pkg::REG_RANGE_HIGH:  max_range  = val[15:0];
      tsp_pkg::REG_TILT_START:  tilt_first = val[15:0];
      tsp_pkg::REG_TILT_STEP:   tilt_decr  = val[15:0];
      tsp_pkg::REG_TILT_STOP:   tilt_floor = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_spare_reg();
    write_reg(REG_INDEX_W'($urandom_range(int'(tsp_pkg::REG_TILT_STOP) + 1, REG_INDEX_TOP)),
              18'($urandom));
  endtask

  // Present a sample after a random gap (none if steady); hold until taken
  task automatic send_sample(input logic [15:0] rng, input logic [15:0] lum,
                             input bit last);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {lum, rng};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sample(rng, lum, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every predicted point has come out
  task automatic wait_for_points();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_points.size() != 0) @(negedge clk);
  endtask

  // Drain and let a dropped sample in flight finish before a register write
  task automatic settle_block();
    wait_for_points();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Check each accepted point against the oldest prediction
  always @(posedge clk) begin
    point_exp_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected point", out_tdata[16:0], '0);
      end else begin
        want = expected_points.pop_front();
        if (out_tdata[16:0] !== want.x)
          report_mismatch("point_x", out_tdata[16:0], want.x);
        if (out_tdata[33:17] !== want.y)
          report_mismatch("point_y", out_tdata[33:17], want.y);
        if (out_tdata[50:34] !== want.z)
          report_mismatch("point_z", out_tdata[50:34], want.z);
        if (out_tdata[66:51] !== want.inten)
          report_mismatch("point_intensity", 17'(out_tdata[66:51]), 17'(want.inten));
      end
    end
  end

  // Result side: stall at random after each point shows up; ready in steady flow
  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady_flow) begin
        out_tready <= 1'b1;
      end else if (out_tvalid === 1'b1) begin
        stall = $urandom_range(0, 3);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        out_tready <= 1'b1;
        @(posedge clk);
        while (!(out_tvalid && out_tready)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
      end
    end
  end

  // Range extremes and limits under the reset settings
  task automatic test_reset_defaults();
    send_sample(16'd0,     16'h0000, 1'b0);
    send_sample(16'd5,     16'hFFFF, 1'b0);
    send_sample(16'd6,     16'hFFFF, 1'b0);
    send_sample(16'd2999,  16'h0000, 1'b0);
    send_sample(16'd3000,  16'hA5A5, 1'b0);
    send_sample(16'hFFFF,  16'h5A5A, 1'b0);
    send_sample(16'd1500,  16'h8001, 1'b1);
  endtask

  // Walk the beam across the window edges up to saturation
  task automatic test_window_and_overflow();
    int k;
    logic [15:0] rng;
    settle_block();
    write_reg(tsp_pkg::REG_ANGLE_START, 18'd4000);
    write_reg(tsp_pkg::REG_ANGLE_STEP,  18'd12000);
    write_reg(tsp_pkg::REG_ANGLE_END,   HIGHEST_ANGLE);
    write_reg(tsp_pkg::REG_RANGE_LOW,   18'd0);
    write_reg(tsp_pkg::REG_RANGE_HIGH,  18'hFFFF);
    write_spare_reg();
    for (k = 0; k < 12; k++) begin
      case (k)
        0: rng = 16'd1;
        1: rng = 16'hFFFE;
        4: rng = 16'hFFFF;
        default: rng = 16'($urandom);
      endcase
      send_sample(rng, 16'($urandom), k == 11);
    end
  endtask

  // Tilt stepping, underflow wrap, stuck tilt and zero beam step
  task automatic test_tilt_wrap();
    int k;
    settle_block();
    write_reg(tsp_pkg::REG_ANGLE_START, LOWEST_ANGLE);
    write_reg(tsp_pkg::REG_ANGLE_STEP,  18'd0);
    write_reg(tsp_pkg::REG_ANGLE_END,   18'h20001);
    write_reg(tsp_pkg::REG_TILT_START,  18'd300);
    write_reg(tsp_pkg::REG_TILT_STEP,   18'd200);
    write_reg(tsp_pkg::REG_TILT_STOP,   18'd0);
    for (k = 0; k < 3; k++) send_sample(16'd40000, 16'($urandom), 1'b1);
    send_sample(16'd1000, 16'($urandom), 1'b0);
    send_sample(16'd1000, 16'($urandom), 1'b1);
    settle_block();
    write_reg(tsp_pkg::REG_TILT_START, 18'hFFFF);
    write_reg(tsp_pkg::REG_TILT_STEP,  18'hFFFF);
    write_reg(tsp_pkg::REG_TILT_STOP,  18'hFFFF);
    send_sample(16'd2000, 16'($urandom), 1'b1);
    settle_block();
    write_reg(tsp_pkg::REG_TILT_STEP, 18'd0);
    send_sample(16'd2000, 16'($urandom), 1'b1);
    send_sample(16'd2000, 16'($urandom), 1'b1);
  endtask

  // Pick a new setting for every register, extremes included
  task automatic randomize_settings();
    int tmp;
    logic [17:0] val;
    case ($urandom_range(0, 9))
      0: val = LOWEST_ANGLE;
      1: val = HIGHEST_ANGLE;
      2: val = 18'($urandom);
      default: begin
        tmp = int'($urandom_range(0, 36000)) - 20000;
        val = tmp[17:0];
      end
    endcase
    write_reg(tsp_pkg::REG_ANGLE_START, val);
    case ($urandom_range(0, 9))
      0: val = 18'd0;
      1: val = 18'hFFFF;
      2: val = 18'd1;
      3: val = 18'($urandom_range(0, 65535));
      default: val = 18'($urandom_range(1, 3000));
    endcase
    write_reg(tsp_pkg::REG_ANGLE_STEP, val);
    case ($urandom_range(0, 9))
      0: val = LOWEST_ANGLE;
      1: val = 18'($urandom);
      2: val = 18'($urandom_range(20000, BEAM_TOP));
      default: val = HIGHEST_ANGLE;
    endcase
    write_reg(tsp_pkg::REG_ANGLE_END, val);
    case ($urandom_range(0, 9))
      0: val = 18'hFFFF;
      1: val = 18'($urandom_range(0, 65535));
      default: val = 18'($urandom_range(0, 200));
    endcase
    write_reg(tsp_pkg::REG_RANGE_LOW, val);
    case ($urandom_range(0, 9))
      0: val = 18'd0;
      1: val = 18'($urandom_range(0, 65535));
      default: val = 18'($urandom_range(2000, 65535));
    endcase
    write_reg(tsp_pkg::REG_RANGE_HIGH, val);
    case ($urandom_range(0, 5))
      0: val = 18'd0;
      1: val = 18'hFFFF;
      default: val = 18'($urandom_range(0, 65535));
    endcase
    write_reg(tsp_pkg::REG_TILT_START, val);
    case ($urandom_range(0, 5))
      0: val = 18'd0;
      1: val = 18'hFFFF;
      2: val = 18'($urandom_range(0, 65535));
      default: val = 18'($urandom_range(0, 4000));
    endcase
    write_reg(tsp_pkg::REG_TILT_STEP, val);
    case ($urandom_range(0, 5))
      0: val = 18'd0;
      1: val = 18'hFFFF;
      default: val = 18'($urandom_range(0, 65535));
    endcase
    write_reg(tsp_pkg::REG_TILT_STOP, val);
    if ($urandom_range(0, 3) == 0) write_spare_reg();
  endtask

  // Phases of random settings, each followed by well-formed scans with noise
  task automatic test_random_scans();
    int phase, target, scan_len, k;
    logic [15:0] rng;
    bit last;
    phase = 0;
    while (items_sent < TOTAL_ITEMS && phase < MAX_PHASES) begin
      settle_block();
      randomize_settings();
      steady_flow = ($urandom_range(0, 3) == 0);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        scan_len = $urandom_range(1, 40);
        for (k = 0; k < scan_len && items_sent < target; k++) begin
          if ($urandom_range(0, 9) == 0 || int'(max_range) <= int'(min_range) + 1)
            rng = 16'($urandom);
          else
            rng = 16'($urandom_range(int'(min_range) + 1, int'(max_range) - 1));
          // mostly one mark per scan, now and then an early one
          last = (k == scan_len - 1) || ($urandom_range(0, 29) == 0);
          send_sample(rng, 16'($urandom), last);
          if ($urandom_range(0, 49) == 0) wait_for_points();
        end
      end
      phase++;
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    // register defaults as loaded by reset
    beam_first = -18'sd32768;
    beam_incr  = 16'd182;
    beam_limit = 18'sd32768;
    min_range  = 16'd5;
    max_range  = 16'd3000;
    tilt_first = 16'd32768;
    tilt_decr  = 16'd182;
    tilt_floor = 16'd8192;
    beam_pos   = beam_first;
    tilt_pos   = tilt_first;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_window_and_overflow();
    test_tilt_wrap();
    test_random_scans();

    settle_block();
    if (expected_points.size() != 0)
      report_mismatch("points never delivered", 17'(expected_points.size()), '0);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/tsp_pkg.sv
hdl/tsp_alu.sv
hdl/tsp_seq.sv
hdl/tilted_scan_to_point.sv
hdl/tsp_checker.sv
tb/tilted_scan_to_point_tb.sv
